FILE: hdl/bffa_pkg.sv
package bffa_pkg;

    localparam int POOL_BITS = 4096;
    localparam int WORD_BITS = 64;
    localparam int MAP_WORDS = POOL_BITS / WORD_BITS;
    localparam int WIDX_W    = $clog2(MAP_WORDS);
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int UNIT_W    = $clog2(POOL_BITS);
    localparam int ADDR_W    = 48;
    localparam int SIZE_W    = 13;
    localparam int USED_W    = 32;
    localparam int LEN_W     = SIZE_W + 1;
    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_BASE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MODE = CFG_IDX_W'(1);

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] address;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] result_address;
        logic              ok;
        logic [USED_W-1:0] used_amount;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_MARK_RD,
        S_MARK_WR,
        S_FIN
    } state_t;

endpackage

FILE: hdl/bitmap_first_fit_allocator.sv
// Size-zero, bump-mode and out-of-pool free requests go from decode straight to finish.
// Bitmap allocate: scans one 64-bit map word per cycle (up to 64 words), then
// read-modify-writes each map word the run touches; free likewise.
// One request in flight at a time; a new one is accepted only once the response is registered.
// Reset: async active-low; map reads as all clear via per-word valid bits,
// counters, base, bump pointer and mode go to zero. No clearing pass.
module bitmap_first_fit_allocator
    import bffa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  req_t                 req,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output rsp_t                 rsp,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data
);

    state_t state_reg, state_next;

    logic [ADDR_W-1:0]    base_reg;
    logic [ADDR_W-1:0]    bump_reg, bump_next;
    logic                 mode_reg;
    logic [USED_W-1:0]    used_reg, used_next;
    req_t                 item_reg;

    logic [ADDR_W-1:0]    res_reg, res_next;
    logic                 ok_reg, ok_next;
    logic [SIZE_W-1:0]    amt_reg, amt_next;
    logic                 upd_reg, upd_next;
    logic                 add_reg, add_next;

    logic [UNIT_W-1:0]    rstart_reg, rstart_next;
    logic [UNIT_W-1:0]    rlast_reg, rlast_next;
    logic                 set_reg, set_next;
    logic [WIDX_W-1:0]    wptr_reg, wptr_next;

    logic [WIDX_W:0]      sptr_reg, sptr_next;
    logic                 pend_reg, pend_next;
    logic [WIDX_W-1:0]    rword_reg, rword_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [UNIT_W-1:0]    rstart_scan_reg, rstart_scan_next;

    logic                 rsp_valid_reg, rsp_valid_next;
    rsp_t                 rsp_reg, rsp_next;

    // map memory
    logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
    logic [WORD_BITS-1:0] rdata_reg;
    logic [MAP_WORDS-1:0] wvalid_reg;
    logic                 mem_re, mem_we;
    logic [WIDX_W-1:0]    mem_raddr;
    logic [WORD_BITS-1:0] mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rdata_reg <= map_mem[mem_raddr];
        end
        if (mem_we)
        begin
            map_mem[wptr_reg] <= mem_wdata;
        end
    end

    // word data as seen by scan and mark (unwritten words are clear)
    logic [WORD_BITS-1:0] word_d;

    // scan datapath
    logic [WORD_BITS-1:0] win_p [BIT_W];
    logic [WORD_BITS-1:0] win_acc;
    logic [BIT_W:0]       win_off;
    logic [BIT_W-1:0]     win_first;
    logic [BIT_W:0]       tz, clz;
    logic [LEN_W-1:0]     lead_len;
    logic                 lead_hit, win_hit;
    logic [UNIT_W-1:0]    lead_start, word_base;

    assign word_base = {rword_reg, BIT_W'(0)};

    always_comb
    begin
        win_p[0] = ~word_d;
        for (int k = 1; k < BIT_W; k++)
        begin
            win_p[k] = win_p[k-1] & (win_p[k-1] >> (1 << (k - 1)));
        end
        win_acc = '1;
        win_off = '0;
        for (int k = 0; k < BIT_W; k++)
        begin
            if (item_reg.size[k])
            begin
                win_acc = win_acc & (win_p[k] >> win_off);
                win_off = win_off + (BIT_W+1)'(1 << k);
            end
        end
        win_first = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--)
        begin
            if (win_acc[j])
            begin
                win_first = BIT_W'(j);
            end
        end
        tz = (BIT_W+1)'(WORD_BITS);
        for (int j = WORD_BITS - 1; j >= 0; j--)
        begin
            if (word_d[j])
            begin
                tz = (BIT_W+1)'(j);
            end
        end
        clz = (BIT_W+1)'(WORD_BITS);
        for (int j = 0; j < WORD_BITS; j++)
        begin
            if (word_d[j])
            begin
                clz = (BIT_W+1)'(WORD_BITS - 1 - j);
            end
        end
    end

    assign word_d     = wvalid_reg[pend_reg ? rword_reg : wptr_reg] ? rdata_reg : '0;
    assign lead_len   = len_reg + LEN_W'(tz);
    assign lead_hit   = lead_len >= LEN_W'(item_reg.size);
    assign lead_start = (len_reg != '0) ? rstart_scan_reg : word_base;
    assign win_hit    = (item_reg.size[SIZE_W-1:BIT_W] == '0) && (win_acc != '0);

    // free range decode
    logic [ADDR_W-1:0]    free_off;
    logic                 free_inpool;
    logic [LEN_W-1:0]     free_excl;
    logic                 free_fits;
    logic [UNIT_W-1:0]    free_last;
    logic [SIZE_W-1:0]    free_cnt;

    assign free_off    = item_reg.address - base_reg;
    assign free_inpool = (free_off[ADDR_W-1:UNIT_W] == '0);
    assign free_excl   = LEN_W'(free_off[UNIT_W-1:0]) + LEN_W'(item_reg.size);
    assign free_fits   = free_excl <= LEN_W'(POOL_BITS);
    assign free_last   = free_fits ? UNIT_W'(free_excl - LEN_W'(1)) : UNIT_W'(POOL_BITS - 1);
    assign free_cnt    = SIZE_W'(free_last) - SIZE_W'(free_off[UNIT_W-1:0]) + SIZE_W'(1);

    // mark mask
    logic [BIT_W-1:0]     mk_lo, mk_hi;
    logic [WORD_BITS-1:0] mk_mask;

    assign mk_lo     = (wptr_reg == rstart_reg[UNIT_W-1:BIT_W]) ? rstart_reg[BIT_W-1:0] : '0;
    assign mk_hi     = (wptr_reg == rlast_reg[UNIT_W-1:BIT_W]) ? rlast_reg[BIT_W-1:0] : '1;
    assign mk_mask   = ({WORD_BITS{1'b1}} << mk_lo) & ({WORD_BITS{1'b1}} >> (~mk_hi));
    assign mem_wdata = set_reg ? (word_d | mk_mask) : (word_d & ~mk_mask);

    // used counter update
    logic [USED_W:0]      used_sum;
    assign used_sum = {1'b0, used_reg} + (USED_W+1)'(amt_reg);

    // next state and datapath
    always_comb
    begin
        state_next       = state_reg;
        bump_next        = bump_reg;
        used_next        = used_reg;
        res_next         = res_reg;
        ok_next          = ok_reg;
        amt_next         = amt_reg;
        upd_next         = upd_reg;
        add_next         = add_reg;
        rstart_next      = rstart_reg;
        rlast_next       = rlast_reg;
        set_next         = set_reg;
        wptr_next        = wptr_reg;
        sptr_next        = sptr_reg;
        pend_next        = 1'b0;
        rword_next       = rword_reg;
        len_next         = len_reg;
        rstart_scan_next = rstart_scan_reg;
        rsp_valid_next   = rsp_valid_reg;
        rsp_next         = rsp_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                res_next  = '0;
                ok_next   = 1'b0;
                upd_next  = 1'b0;
                add_next  = 1'b1;
                amt_next  = item_reg.size;
                state_next = S_FIN;
                if (item_reg.size == '0)
                begin
                    ok_next = 1'b0;
                end
                else if (mode_reg)
                begin
                    ok_next = 1'b1;
                    if (item_reg.operation == OP_ALLOC)
                    begin
                        res_next  = bump_reg;
                        bump_next = bump_reg + ADDR_W'(item_reg.size);
                        upd_next  = 1'b1;
                    end
                end
                else if (item_reg.operation == OP_ALLOC)
                begin
                    sptr_next  = '0;
                    len_next   = '0;
                    set_next   = 1'b1;
                    state_next = S_SCAN;
                end
                else
                begin
                    add_next = 1'b0;
                    set_next = 1'b0;
                    ok_next  = free_inpool && free_fits;
                    if (free_inpool)
                    begin
                        upd_next    = 1'b1;
                        amt_next    = free_cnt;
                        rstart_next = free_off[UNIT_W-1:0];
                        rlast_next  = free_last;
                        wptr_next   = free_off[UNIT_W-1:BIT_W];
                        state_next  = S_MARK_RD;
                    end
                end
            end
            S_SCAN:
            begin
                if (!sptr_reg[WIDX_W])
                begin
                    pend_next  = 1'b1;
                    rword_next = sptr_reg[WIDX_W-1:0];
                    sptr_next  = sptr_reg + (WIDX_W+1)'(1);
                end
                if (pend_reg)
                begin
                    if (lead_hit || win_hit)
                    begin
                        pend_next   = 1'b0;
                        rstart_next = lead_hit ? lead_start : (word_base | UNIT_W'(win_first));
                        rlast_next  = UNIT_W'(rstart_next + UNIT_W'(item_reg.size) - UNIT_W'(1));
                        wptr_next   = rstart_next[UNIT_W-1:BIT_W];
                        res_next    = base_reg + ADDR_W'(rstart_next);
                        ok_next     = 1'b1;
                        upd_next    = 1'b1;
                        state_next  = S_MARK_RD;
                    end
                    else if (rword_reg == WIDX_W'(MAP_WORDS - 1))
                    begin
                        pend_next  = 1'b0;
                        state_next = S_FIN;
                    end
                    else if (tz == (BIT_W+1)'(WORD_BITS))
                    begin
                        len_next         = lead_len;
                        rstart_scan_next = lead_start;
                    end
                    else
                    begin
                        len_next         = LEN_W'(clz);
                        rstart_scan_next = word_base + UNIT_W'((BIT_W+1)'(WORD_BITS) - clz);
                    end
                end
            end
            S_MARK_RD:
            begin
                state_next = S_MARK_WR;
            end
            S_MARK_WR:
            begin
                if (wptr_reg == rlast_reg[UNIT_W-1:BIT_W])
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    wptr_next  = wptr_reg + WIDX_W'(1);
                    state_next = S_MARK_RD;
                end
            end
            S_FIN:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    if (upd_reg && add_reg)
                    begin
                        used_next = used_sum[USED_W] ? '1 : used_sum[USED_W-1:0];
                    end
                    else if (upd_reg)
                    begin
                        used_next = (USED_W'(amt_reg) >= used_reg) ? '0
                                  : used_reg - USED_W'(amt_reg);
                    end
                    rsp_valid_next          = 1'b1;
                    rsp_next.result_address = res_reg;
                    rsp_next.ok             = ok_reg;
                    rsp_next.used_amount    = used_next;
                    state_next              = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // base write also reloads the bump pointer
        if (cfg_valid && cfg_ready && (cfg_index == REG_BASE))
        begin
            bump_next = cfg_data;
        end
    end

    // outputs and memory control
    always_comb
    begin
        req_ready = 1'b0;
        mem_re    = 1'b0;
        mem_we    = 1'b0;
        mem_raddr = wptr_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
            end
            S_SCAN:
            begin
                mem_re    = !sptr_reg[WIDX_W];
                mem_raddr = sptr_reg[WIDX_W-1:0];
            end
            S_MARK_RD:
            begin
                mem_re = 1'b1;
            end
            S_MARK_WR:
            begin
                mem_we = 1'b1;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            base_reg      <= '0;
            bump_reg      <= '0;
            mode_reg      <= 1'b0;
            used_reg      <= '0;
            wvalid_reg    <= '0;
            rsp_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bump_reg      <= bump_next;
            used_reg      <= used_next;
            rsp_valid_reg <= rsp_valid_next;
            pend_reg      <= pend_next;
            if (mem_we)
            begin
                wvalid_reg[wptr_reg] <= 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_BASE)
                begin
                    base_reg <= cfg_data;
                end
                else if (cfg_index == REG_MODE)
                begin
                    mode_reg <= cfg_data[0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            item_reg <= req;
        end
        res_reg         <= res_next;
        ok_reg          <= ok_next;
        amt_reg         <= amt_next;
        upd_reg         <= upd_next;
        add_reg         <= add_next;
        rstart_reg      <= rstart_next;
        rlast_reg       <= rlast_next;
        set_reg         <= set_next;
        wptr_reg        <= wptr_next;
        sptr_reg        <= sptr_next;
        rword_reg       <= rword_next;
        len_reg         <= len_next;
        rstart_scan_reg <= rstart_scan_next;
        rsp_reg         <= rsp_next;
    end

`ifndef SYNTH
    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> state_reg == S_DECODE)
        else $error("accepted word not decoded");

    a_mark_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MARK_WR |-> wptr_reg <= rlast_reg[UNIT_W-1:BIT_W])
        else $error("mark pointer past run end");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.ok || rsp.result_address == '0)
        else $error("failed word carries an address");
`endif

endmodule

FILE: tb/bitmap_first_fit_allocator_tb.sv
module bitmap_first_fit_allocator_tb;
    import bffa_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam logic [ADDR_W-1:0] ADDR_ONES = {ADDR_W{1'b1}};

    typedef enum logic { K_REQ, K_CFG } row_kind_t;

    typedef struct {
        row_kind_t         kind;
        logic              op;      // K_CFG: unused
        int                size;    // K_CFG: register index
        logic [ADDR_W-1:0] addr;    // K_CFG: write data
        bit                typed;
        logic [ADDR_W-1:0] exp_addr;
        logic              exp_ok;
        logic [USED_W-1:0] exp_used;
    } row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 req_valid;
    logic                 req_ready;
    req_t                 req;
    logic                 rsp_valid;
    logic                 rsp_ready;
    rsp_t                 rsp;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ADDR_W-1:0]    cfg_data;

    // shadow of the allocator
    logic [POOL_BITS-1:0] unit_busy;
    logic [USED_W-1:0]    units_used;
    logic [ADDR_W-1:0]    bump_ptr;
    logic [ADDR_W-1:0]    pool_base;
    logic                 bump_on;

    rsp_t pending_rsp[$];
    int   mismatches;
    int   cycles;
    int   words_sent;
    int   words_checked;
    int   cfg_writes;
    bit   no_gaps;
    bit   hold_request;

    logic [ADDR_W-1:0] live_addr[$];
    int                live_size[$];

    bitmap_first_fit_allocator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic void used_grow(int n);
        logic [USED_W:0] s;
        s = {1'b0, units_used} + (USED_W+1)'(n);
        units_used = s[USED_W] ? {USED_W{1'b1}} : s[USED_W-1:0];
    endfunction

    function automatic rsp_t pool_apply(req_t w);
        rsp_t              r;
        int                n;
        int                run_start;
        int                run_len;
        bit                found;
        logic [ADDR_W-1:0] offs;
        logic [ADDR_W:0]   u;
        int                cleared;
        r = '0;
        n = int'(w.size);
        if (n == 0)
            r.ok = 1'b0;
        else if (w.operation == OP_ALLOC)
        begin
            if (bump_on)
            begin
                r.result_address = bump_ptr;
                bump_ptr = bump_ptr + ADDR_W'(n);
                used_grow(n);
                r.ok = 1'b1;
            end
            else
            begin
                run_start = 0;
                run_len = 0;
                found = 0;
                for (int i = 0; i < POOL_BITS; i++)
                begin
                    if (unit_busy[i])
                        run_len = 0;
                    else
                    begin
                        if (run_len == 0)
                            run_start = i;
                        run_len++;
                        if (run_len == n)
                        begin
                            found = 1;
                            break;
                        end
                    end
                end
                if (found)
                begin
                    for (int i = 0; i < n; i++)
                        unit_busy[run_start + i] = 1'b1;
                    used_grow(n);
                    r.result_address = pool_base + ADDR_W'(run_start);
                    r.ok = 1'b1;
                end
            end
        end
        else if (bump_on)
            r.ok = 1'b1;
        else
        begin
            // offset wraps at 48 bits, offset + i does not
            offs = w.address - pool_base;
            cleared = 0;
            r.ok = 1'b1;
            for (int i = 0; i < n; i++)
            begin
                u = {1'b0, offs} + (ADDR_W+1)'(i);
                if (u < POOL_BITS)
                begin
                    unit_busy[u] = 1'b0;
                    cleared++;
                end
                else
                    r.ok = 1'b0;
            end
            if (USED_W'(cleared) >= units_used)
                units_used = '0;
            else
                units_used = units_used - USED_W'(cleared);
        end
        r.used_amount = units_used;
        return r;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_rsp.size() == 0)
                report("unexpected word, result_address", rsp.result_address, 0);
            else
            begin
                rsp_t e;
                e = pending_rsp.pop_front();
                if (rsp.result_address !== e.result_address)
                    report("result_address", rsp.result_address, e.result_address);
                if (rsp.ok !== e.ok)
                    report("ok", rsp.ok, e.ok);
                if (rsp.used_amount !== e.used_amount)
                    report("used_amount", rsp.used_amount, e.used_amount);
                words_checked++;
            end
        end
    end

    // receiver: random stalls, one long hold-off on request
    initial
    begin
        int n;
        rsp_ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            n = no_gaps ? 0 : $urandom_range(0, 13);
            if (hold_request)
            begin
                hold_request = 0;
                n = 400;
            end
            if (n > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(rsp_valid && rsp_ready));
        end
    end

    task automatic send_word(input logic op, input int size, input logic [ADDR_W-1:0] addr,
                             output rsp_t predicted);
        int   gap;
        req_t w;
        gap = no_gaps ? 0 : $urandom_range(0, 13);
        w.operation = op;
        w.size = SIZE_W'(size);
        w.address = addr;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req <= w;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!(req_valid && req_ready));
        predicted = pool_apply(w);
        words_sent++;
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
        drain();
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        if (idx == REG_BASE)
        begin
            pool_base = data;
            bump_ptr = data;
        end
        else if (idx == REG_MODE)
            bump_on = data[0];
        cfg_writes++;
    endtask

    task automatic random_word();
        rsp_t p;
        int   pick;
        int   sz;
        int   k;
        pick = $urandom_range(0, 99);
        if (pick < 50)
        begin
            sz = (pick < 3) ? $urandom_range(0, 8191) :
                 (pick < 6) ? $urandom_range(100, 4096) : $urandom_range(1, 70);
            send_word(OP_ALLOC, sz, ADDR_W'({$urandom, $urandom}), p);
            pending_rsp.push_back(p);
            if (p.ok && !bump_on)
            begin
                live_addr.push_back(p.result_address);
                live_size.push_back(sz);
            end
        end
        else if (pick < 85 && live_addr.size() > 0)
        begin
            k = $urandom_range(0, live_addr.size() - 1);
            send_word(OP_FREE, live_size[k], live_addr[k], p);
            pending_rsp.push_back(p);
            live_addr.delete(k);
            live_size.delete(k);
        end
        else if (pick < 93)
        begin
            send_word(OP_FREE, $urandom_range(0, 200),
                      pool_base + ADDR_W'($urandom_range(0, 4200)), p);
            pending_rsp.push_back(p);
        end
        else
        begin
            send_word(1'($urandom_range(0, 1)), $urandom_range(0, 8191),
                      ADDR_W'({$urandom, $urandom}), p);
            pending_rsp.push_back(p);
        end
    endtask

    row_t steps[$];

    function automatic row_t rq(logic op, int size, logic [ADDR_W-1:0] addr);
        row_t r;
        r = '{K_REQ, op, size, addr, 0, '0, 1'b0, '0};
        return r;
    endfunction

    function automatic row_t rx(logic op, int size, logic [ADDR_W-1:0] addr,
                                logic [ADDR_W-1:0] ea, logic eo, logic [USED_W-1:0] eu);
        row_t r;
        r = '{K_REQ, op, size, addr, 1, ea, eo, eu};
        return r;
    endfunction

    function automatic row_t rc(int idx, logic [ADDR_W-1:0] data);
        row_t r;
        r = '{K_CFG, 1'b0, idx, data, 0, '0, 1'b0, '0};
        return r;
    endfunction

    initial
    begin
        rsp_t p;
        rsp_t e;
        logic [ADDR_W-1:0] b;
        rst_n <= 1'b0;
        req_valid <= 1'b0;
        req <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        mismatches = 0;
        cycles = 0;
        words_sent = 0;
        words_checked = 0;
        cfg_writes = 0;
        no_gaps = 0;
        hold_request = 0;
        unit_busy = '0;
        units_used = '0;
        bump_ptr = '0;
        pool_base = '0;
        bump_on = 1'b0;

        steps = '{
            rx(OP_ALLOC, 0, 0, 0, 1'b0, 0),
            rx(OP_FREE, 0, 5, 0, 1'b0, 0),
            rx(OP_ALLOC, 1, 0, 0, 1'b1, 1),
            rx(OP_ALLOC, 8191, 0, 0, 1'b0, 1),
            rx(OP_ALLOC, 4096, 0, 0, 1'b0, 1),
            rx(OP_ALLOC, 63, ADDR_ONES, 1, 1'b1, 64),
            rx(OP_ALLOC, 64, 0, 64, 1'b1, 128),
            rx(OP_FREE, 1, 0, 0, 1'b1, 127),
            rx(OP_ALLOC, 1, 0, 0, 1'b1, 128),
            rx(OP_FREE, 2, 4095, 0, 1'b0, 127),
            rx(OP_FREE, 5, ADDR_ONES, 0, 1'b0, 127),
            rx(OP_FREE, 4096, 0, 0, 1'b1, 0),
            rx(OP_ALLOC, 4096, 0, 0, 1'b1, 4096),
            rx(OP_ALLOC, 1, 0, 0, 1'b0, 4096),
            rx(OP_FREE, 8191, 100, 0, 1'b0, 100),
            rx(OP_ALLOC, 5000, 0, 0, 1'b0, 100),
            rq(OP_ALLOC, 17, 0),
            rq(OP_FREE, 3, 2000),
            rc(REG_BASE, ADDR_ONES - 15),
            rq(OP_ALLOC, 32, 0),
            rq(OP_FREE, 4, 48'h10),
            rc(REG_MODE, 1),
            rq(OP_ALLOC, 8191, 0),
            rq(OP_ALLOC, 100, 0),
            rq(OP_FREE, 3, 0),
            rq(OP_ALLOC, 0, 0)
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (steps[i])
        begin
            if (steps[i].kind == K_CFG)
                write_reg(CFG_IDX_W'(steps[i].size), steps[i].addr);
            else
            begin
                send_word(steps[i].op, steps[i].size, steps[i].addr, p);
                if (steps[i].typed)
                begin
                    e.result_address = steps[i].exp_addr;
                    e.ok = steps[i].exp_ok;
                    e.used_amount = steps[i].exp_used;
                    pending_rsp.push_back(e);
                end
                else
                    pending_rsp.push_back(p);
            end
        end

        for (int ph = 0; ph < 8; ph++)
        begin
            b = (ph == 0) ? '0 : (ph == 1) ? ADDR_ONES : ADDR_W'({$urandom, $urandom});
            write_reg(REG_BASE, b);
            write_reg(REG_MODE, (ph == 3 || ph == 6) ? ADDR_W'(1) : ADDR_W'(0));
            live_addr.delete();
            live_size.delete();
            if (ph == 2)
            begin
                // receiver stalls long while words keep coming
                hold_request = 1;
                no_gaps = 1;
                repeat (20) random_word();
                no_gaps = 0;
            end
            if (ph == 5)
                no_gaps = 1;
            for (int j = 0; j < 50; j++)
            begin
                random_word();
                if (j == 25)
                    drain();
            end
            no_gaps = 0;
        end

        drain();
        $display("sent %0d request words, checked %0d responses, %0d register writes",
                 words_sent, words_checked, cfg_writes);
        $display("covered bitmap and bump modes, edge sizes, out-of-pool frees, base wrap");
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: sim.f
hdl/bffa_pkg.sv
hdl/bitmap_first_fit_allocator.sv
tb/bitmap_first_fit_allocator_tb.sv
